### rtl/mnrt_pkg.sv
`default_nettype none

package mnrt_pkg;

  // Fixed field widths of the message and of the route.
  localparam int unsigned StatusW = 8;
  localparam int unsigned DataW   = 7;
  localparam int unsigned RouteW  = 8;
  localparam int unsigned ChanW   = 4;
  localparam int unsigned KindW   = 4;

  // Note store: one entry per channel and note.
  localparam int unsigned NoteAddrW = ChanW + DataW;
  localparam int unsigned NoteDepth = 1 << NoteAddrW;
  localparam int unsigned ChanCount = 1 << ChanW;

  // Message kinds (high nibble of the status byte).
  localparam logic [KindW-1:0] KindNoteOff = 4'h8;
  localparam logic [KindW-1:0] KindNoteOn  = 4'h9;
  localparam logic [KindW-1:0] KindControl = 4'hB;

  // Sustain pedal controller number.
  localparam logic [DataW-1:0] SustainCtrl = 7'd64;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_we;
    logic accept;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### rtl/mnrt_ram.sv
`default_nettype none

module mnrt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/mnrt_ctrl.sv
`default_nettype none

module mnrt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output mnrt_pkg::cmd_t     cmd_o,
  input  wire mnrt_pkg::sts_t sts_i
);

  import mnrt_pkg::*;

  state_e state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // No item is taken while the note store is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_ready_o)
    else $error("input ready during clearing pass");

  // A transfer in is always followed by the lookup cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == ST_LOOK))
    else $error("lookup did not follow an accepted item");

  // A free output register lets the lookup finish at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_LOOK) && sts_i.out_free) |=> (state_q == ST_IDLE))
    else $error("lookup stalled with a free output register");

endmodule

`default_nettype wire

### rtl/mnrt_dp.sv
`default_nettype none

module mnrt_dp #(
  parameter int unsigned StoreW = 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire mnrt_pkg::cmd_t                  cmd_i,
  output mnrt_pkg::sts_t                       sts_o,
  input  wire logic [mnrt_pkg::RouteW-1:0]     cfg_wdata_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [mnrt_pkg::StatusW-1:0]    status_byte_i,
  input  wire logic [mnrt_pkg::DataW-1:0]      data_one_i,
  input  wire logic [mnrt_pkg::DataW-1:0]      data_two_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [mnrt_pkg::RouteW-1:0]     route_mask_o,
  output logic      [mnrt_pkg::StatusW-1:0]    out_status_o,
  output logic      [mnrt_pkg::DataW-1:0]      out_data_one_o,
  output logic      [mnrt_pkg::DataW-1:0]      out_data_two_o
);

  import mnrt_pkg::*;

  logic [StoreW-1:0]    conn_q;
  logic [NoteAddrW-1:0] clr_addr_q;
  logic [StoreW-1:0]    sus_q [ChanCount];

  logic [KindW-1:0]     kind;
  logic [ChanW-1:0]     chan;
  logic [NoteAddrW-1:0] slot;
  logic                 is_release;
  logic                 is_press;
  logic                 is_sus;
  logic                 sus_press;

  logic                 ram_we;
  logic [NoteAddrW-1:0] ram_waddr;
  logic [StoreW-1:0]    ram_wdata;
  logic                 ram_re;
  logic [StoreW-1:0]    ram_rdata;

  logic                 sel_ram_q;
  logic [StoreW-1:0]    mask_q, mask_d;
  logic [StatusW-1:0]   status_q;
  logic [DataW-1:0]     d1_q, d2_q;

  logic                 out_valid_q;
  logic [StoreW-1:0]    out_mask_q;

  // Connection register; only the bits of existing connections are kept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_q <= '0;
    end else if (cfg_we_i) begin
      conn_q <= cfg_wdata_i[StoreW-1:0];
    end
  end

  // Message decode.
  assign kind       = status_byte_i[StatusW-1 -: KindW];
  assign chan       = status_byte_i[ChanW-1:0];
  assign slot       = {chan, data_one_i};
  assign is_press   = (kind == KindNoteOn) && (data_two_i != '0);
  assign is_release = (kind == KindNoteOff) ||
                      ((kind == KindNoteOn) && (data_two_i == '0));
  assign is_sus     = (kind == KindControl) && (data_one_i == SustainCtrl);
  assign sus_press  = is_sus && (data_two_i != '0);

  // Mask known at accept time; releases of notes take the store instead.
  always_comb begin
    if (is_sus && !sus_press) begin
      mask_d = sus_q[chan];
    end else begin
      mask_d = conn_q;
    end
  end

  // Clearing pass address after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_we) begin
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  // Note store port control: the clearing pass or a note press writes.
  assign ram_we    = cmd_i.clr_we || (cmd_i.accept && is_press);
  assign ram_waddr = cmd_i.clr_we ? clr_addr_q : slot;
  assign ram_wdata = cmd_i.clr_we ? '0 : conn_q;
  assign ram_re    = cmd_i.accept && is_release;

  mnrt_ram #(
    .Width (StoreW),
    .Depth (NoteDepth)
  ) u_note_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (slot),
    .rdata_o (ram_rdata)
  );

  // Sustain store per channel, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(ChanCount); i++) begin
        sus_q[i] <= '0;
      end
    end else if (cmd_i.accept && sus_press) begin
      sus_q[chan] <= conn_q;
    end
  end

  // Item capture at the input transfer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sel_ram_q <= is_release;
      mask_q    <= mask_d;
      status_q  <= status_byte_i;
      d1_q      <= data_one_i;
      d2_q      <= data_two_i;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_mask_q     <= sel_ram_q ? ram_rdata : mask_q;
      out_status_o   <= status_q;
      out_data_one_o <= d1_q;
      out_data_two_o <= d2_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign route_mask_o = RouteW'(out_mask_q);

  assign sts_o.clear_last = &clr_addr_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // The clearing pass and item handling never share the store port.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.accept && cmd_i.clr_we))
    else $error("item accepted during clearing pass");

  // A loaded result is offered in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> out_valid_q)
    else $error("loaded result not offered");

  // The output register is loaded only when it is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before its transfer");

endmodule

`default_nettype wire

### rtl/midi_note_off_route_table_top.sv
// An accepted item is captured (releases of notes also read the note store), then loaded into the output register.
// A new item is taken only after the previous one has been loaded into the output register.
// An item may be taken while the previous result waits in the output register.
// Reset (async, active low) clears the connection register and the sustain store,
// then a clearing pass writes the 2048-entry note store, one entry a cycle,
// during which no item is taken; configuration writes still land.
`default_nettype none

module midi_note_off_route_table_top #(
  parameter int unsigned NUM_CONNECTIONS = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [mnrt_pkg::RouteW-1:0]  cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [mnrt_pkg::StatusW-1:0] status_byte_i,
  input  wire logic [mnrt_pkg::DataW-1:0]   data_one_i,
  input  wire logic [mnrt_pkg::DataW-1:0]   data_two_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [mnrt_pkg::RouteW-1:0]  route_mask_o,
  output logic      [mnrt_pkg::StatusW-1:0] out_status_o,
  output logic      [mnrt_pkg::DataW-1:0]   out_data_one_o,
  output logic      [mnrt_pkg::DataW-1:0]   out_data_two_o
);

  import mnrt_pkg::*;

  // Stored masks hold only the connections that exist and fit the route field.
  localparam int unsigned StoreW =
    (NUM_CONNECTIONS < RouteW) ? NUM_CONNECTIONS : RouteW;

  cmd_t cmd;
  sts_t sts;

  mnrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  mnrt_dp #(
    .StoreW (StoreW)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_wdata_i    (cfg_wdata_i),
    .cfg_we_i       (cfg_we_i),
    .status_byte_i  (status_byte_i),
    .data_one_i     (data_one_i),
    .data_two_i     (data_two_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .route_mask_o   (route_mask_o),
    .out_status_o   (out_status_o),
    .out_data_one_o (out_data_one_o),
    .out_data_two_o (out_data_two_o)
  );

endmodule

`default_nettype wire

### verif/tb_midi_note_off_route_table_top.sv
module tb_midi_note_off_route_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mnrt_pkg::*;

  localparam int unsigned Conns = 8;
  localparam logic [RouteW-1:0] ConnMask = (Conns >= RouteW) ? '1 : RouteW'((1 << Conns) - 1);

  // Message kinds that the block passes with the live mask.
  localparam logic [KindW-1:0] KindPolyPress = 4'hA;
  localparam logic [KindW-1:0] KindProgram   = 4'hC;
  localparam logic [KindW-1:0] KindChanPress = 4'hD;
  localparam logic [KindW-1:0] KindPitchBend = 4'hE;
  localparam logic [KindW-1:0] KindSystem    = 4'hF;

  localparam int unsigned WatchdogLimit = 10000;
  localparam int unsigned ChunkCount    = 24;
  localparam int unsigned ChunkItems    = 50;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_SINK, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [DataW-1:0]   data_one;
    logic [DataW-1:0]   data_two;
  } midi_msg_t;

  typedef struct packed {
    logic [RouteW-1:0]  route;
    logic [StatusW-1:0] status;
    logic [DataW-1:0]   data_one;
    logic [DataW-1:0]   data_two;
  } routed_msg_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [RouteW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [StatusW-1:0] status_byte_i = '0;
  logic [DataW-1:0] data_one_i = '0;
  logic [DataW-1:0] data_two_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [RouteW-1:0] route_mask_o;
  logic [StatusW-1:0] out_status_o;
  logic [DataW-1:0] out_data_one_o;
  logic [DataW-1:0] out_data_two_o;

  // Shadow copies of the connection register and of both route stores.
  logic [RouteW-1:0] live_conns = '0;
  logic [RouteW-1:0] note_routes [NoteDepth] = '{default: '0};
  logic [RouteW-1:0] sustain_routes [ChanCount] = '{default: '0};

  midi_msg_t pending_msgs[$];
  routed_msg_t expected_routes[$];
  int unsigned items_queued = 0;
  int unsigned items_sent = 0;
  int unsigned items_taken = 0;
  int unsigned route_errors = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap_pct = 0;
  int unsigned sink_stall_pct = 0;

  midi_note_off_route_table_top #(
    .NUM_CONNECTIONS(Conns)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .status_byte_i  (status_byte_i),
    .data_one_i     (data_one_i),
    .data_two_i     (data_two_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .route_mask_o   (route_mask_o),
    .out_status_o   (out_status_o),
    .out_data_one_o (out_data_one_o),
    .out_data_two_o (out_data_two_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Route one message: note-on and sustain press record the live mask, their
  // releases replay the recorded one, everything else takes the live mask.
  function automatic routed_msg_t predict_route(midi_msg_t m);
    logic [KindW-1:0] kind;
    logic [ChanW-1:0] chan;
    logic [NoteAddrW-1:0] slot;
    logic [RouteW-1:0] now_mask;
    logic [RouteW-1:0] mask;
    kind = m.status[StatusW-1 -: KindW];
    chan = m.status[ChanW-1:0];
    slot = {chan, m.data_one};
    now_mask = live_conns & ConnMask;
    mask = now_mask;
    if (kind == KindNoteOff) begin
      mask = note_routes[slot];
    end else if (kind == KindNoteOn) begin
      if (m.data_two == '0) begin
        mask = note_routes[slot];
      end else begin
        note_routes[slot] = now_mask;
      end
    end else if (kind == KindControl && m.data_one == SustainCtrl) begin
      if (m.data_two == '0) begin
        mask = sustain_routes[chan];
      end else begin
        sustain_routes[chan] = now_mask;
      end
    end
    return '{route: mask & ConnMask, status: m.status, data_one: m.data_one,
             data_two: m.data_two};
  endfunction

  // Mostly note and sustain traffic on a narrow band of notes so that
  // releases find the entries that earlier presses wrote.
  function automatic midi_msg_t random_msg();
    midi_msg_t m;
    int unsigned pick;
    logic [ChanW-1:0] chan;
    logic [DataW-1:0] note;
    pick = $urandom_range(0, 99);
    chan = ChanW'($urandom_range(0, ChanCount - 1));
    note = ($urandom_range(0, 3) == 0) ? DataW'($urandom_range(0, 127))
                                       : DataW'($urandom_range(60, 67));
    m.data_one = note;
    m.data_two = DataW'($urandom_range(1, 127));
    if (pick < 30) begin
      m.status = {KindNoteOn, chan};
    end else if (pick < 52) begin
      m.status = {KindNoteOff, chan};
      m.data_two = DataW'($urandom_range(0, 127));
    end else if (pick < 62) begin
      m.status = {KindNoteOn, chan};
      m.data_two = '0;
    end else if (pick < 74) begin
      m.status = {KindControl, chan};
      m.data_one = SustainCtrl;
      if ($urandom_range(0, 1) == 0) m.data_two = '0;
    end else if (pick < 82) begin
      m.status = {KindControl, chan};
      m.data_one = DataW'($urandom_range(0, 127));
      m.data_two = DataW'($urandom_range(0, 127));
    end else if (pick < 92) begin
      case ($urandom_range(0, 4))
        0: m.status = {KindPolyPress, chan};
        1: m.status = {KindProgram, chan};
        2: m.status = {KindChanPress, chan};
        3: m.status = {KindPitchBend, chan};
        default: m.status = {KindSystem, chan};
      endcase
      m.data_two = DataW'($urandom_range(0, 127));
    end else begin
      m.status = StatusW'($urandom_range(0, 255));
      m.data_one = DataW'($urandom_range(0, 127));
      m.data_two = DataW'($urandom_range(0, 127));
    end
    return m;
  endfunction

  // Append one message to the driver's queue.
  task automatic enqueue_msg(midi_msg_t m);
    pending_msgs = {pending_msgs, m};
    items_queued++;
  endtask

  task automatic queue_msg(logic [StatusW-1:0] status, logic [DataW-1:0] d1,
                           logic [DataW-1:0] d2);
    enqueue_msg('{status: status, data_one: d1, data_two: d2});
  endtask

  // Let every queued message go through and every route come back.
  task automatic wait_drained();
    while (items_taken != items_queued || expected_routes.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_conns(logic [RouteW-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    live_conns = value;
  endtask

  task automatic set_idle(idle_mode_e mode);
    send_gap_pct = (mode == IDLE_SEND) ? 82 : (mode == IDLE_BOTH) ? 15 : 0;
    sink_stall_pct = (mode == IDLE_SINK) ? 82 : (mode == IDLE_BOTH) ? 15 : 0;
  endtask

  task automatic report_route_error(string why, routed_msg_t want, routed_msg_t got);
    route_errors++;
    if (route_errors <= 10) begin
      $display("%0t: %s: expected route %02h status %02h d1 %02h d2 %02h, ",
               $realtime, why, want.route, want.status, want.data_one, want.data_two,
               "got route %02h status %02h d1 %02h d2 %02h",
               got.route, got.status, got.data_one, got.data_two);
    end
  endtask

  // Input driver: holds a message until its transfer, then maybe pauses.
  always @(negedge clk_i) begin
    midi_msg_t m;
    if (in_valid_i && items_taken != items_sent) begin
      // Keep the current message on the bus.
    end else if (rst_ni && pending_msgs.size() != 0 &&
                 $urandom_range(0, 99) >= send_gap_pct) begin
      m = pending_msgs.pop_front();
      items_sent++;
      in_valid_i <= 1'b1;
      status_byte_i <= m.status;
      data_one_i <= m.data_one;
      data_two_i <= m.data_two;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Output side back-pressure.
  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Monitor: predicts on each input transfer, checks each output transfer.
  always @(posedge clk_i) begin
    routed_msg_t got;
    routed_msg_t want;
    logic moved;
    moved = 1'b0;
    if (out_valid_o && out_ready_i) begin
      moved = 1'b1;
      got = '{route: route_mask_o, status: out_status_o, data_one: out_data_one_o,
              data_two: out_data_two_o};
      if (expected_routes.size() == 0) begin
        report_route_error("route with no message pending", '0, got);
      end else begin
        want = expected_routes.pop_front();
        if (got.route != want.route || got.status != want.status ||
            got.data_one != want.data_one || got.data_two != want.data_two) begin
          report_route_error("route mismatch", want, got);
        end
      end
    end
    if (in_valid_i && in_ready_o) begin
      moved = 1'b1;
      want = predict_route('{status: status_byte_i, data_one: data_one_i,
                             data_two: data_two_i});
      expected_routes = {expected_routes, want};
      items_taken++;
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("FAIL midi_note_off_route_table_top");
      $finish;
    end
  end

  initial begin
    logic [RouteW-1:0] conns;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    set_idle(IDLE_NONE);

    // Releases that were never pressed see the cleared stores, then one press.
    queue_msg({KindNoteOff, 4'h0}, 7'd0, 7'd0);
    queue_msg({KindNoteOn, 4'hF}, 7'd127, 7'd0);
    queue_msg({KindControl, 4'h7}, SustainCtrl, 7'd0);
    queue_msg({KindNoteOn, 4'h3}, 7'd10, 7'd100);
    wait_drained();

    // Presses at the field extremes with every connection on, then other kinds.
    write_conns(8'hFF);
    queue_msg({KindNoteOn, 4'h0}, 7'd0, 7'd127);
    queue_msg({KindNoteOn, 4'hF}, 7'd127, 7'd1);
    queue_msg({KindControl, 4'hF}, SustainCtrl, 7'd127);
    queue_msg(8'h00, 7'd0, 7'd0);
    queue_msg(8'h7F, 7'd127, 7'd127);
    queue_msg({KindPolyPress, 4'h1}, 7'd5, 7'd6);
    queue_msg({KindProgram, 4'h2}, 7'd7, 7'd0);
    queue_msg({KindChanPress, 4'h3}, 7'd127, 7'd0);
    queue_msg({KindPitchBend, 4'h4}, 7'd0, 7'd127);
    queue_msg({KindSystem, 4'h0}, 7'd85, 7'd42);
    queue_msg({KindSystem, 4'hF}, 7'd127, 7'd127);
    queue_msg({KindControl, 4'h5}, 7'd63, 7'd0);
    queue_msg({KindControl, 4'h5}, 7'd65, 7'd127);
    wait_drained();

    // Releases after the live mask has moved replay the recorded mask.
    write_conns(8'hA5);
    queue_msg({KindNoteOff, 4'h0}, 7'd0, 7'd64);
    queue_msg({KindNoteOn, 4'hF}, 7'd127, 7'd0);
    queue_msg({KindControl, 4'hF}, SustainCtrl, 7'd0);
    queue_msg({KindControl, 4'h3}, SustainCtrl, 7'd0);
    queue_msg({KindNoteOn, 4'h0}, 7'd0, 7'd50);
    queue_msg({KindNoteOff, 4'h0}, 7'd0, 7'd0);
    wait_drained();

    // Random traffic in chunks, each with its own mask and idling.
    for (int chunk = 0; chunk < ChunkCount; chunk++) begin
      case (chunk % 6)
        0: conns = 8'h00;
        1: conns = 8'hFF;
        2: conns = 8'h01;
        3: conns = 8'h80;
        default: conns = RouteW'($urandom_range(0, 255));
      endcase
      write_conns(conns);
      set_idle(idle_mode_e'(chunk % 4));
      for (int i = 0; i < ChunkItems; i++) begin
        enqueue_msg(random_msg());
      end
      wait_drained();
    end

    repeat (8) @(negedge clk_i);
    if (route_errors == 0 && expected_routes.size() == 0) begin
      $display("PASS midi_note_off_route_table_top");
    end else begin
      $display("FAIL midi_note_off_route_table_top");
    end
    $finish;
  end

endmodule
